FILE: src/odtb_pkg.sv
// Shared types and constants of the on/off delay timer bank.
`default_nettype none

package odtb_pkg;

    localparam int unsigned NUM_TIMERS_DEF = 64;
    localparam int unsigned MS_PER_SEC     = 1000;

    // field widths
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned MS_W    = 16;
    localparam int unsigned ID_W    = 6;
    localparam int unsigned DLY_W   = 16;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned SDLY_W  = 26;   // 65535 * 1000 fits here

    // request codes
    localparam logic [KIND_W-1:0] REQ_TICK = 2'd0;
    localparam logic [KIND_W-1:0] REQ_TON  = 2'd1;
    localparam logic [KIND_W-1:0] REQ_TOF  = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REQ_RD,
        S_REQ_WR,
        S_TICK_RD,
        S_TICK_WR,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: src/on_off_delay_timer_bank.sv
// Top level of the on/off delay timer bank: sequencer, count store and shared adder.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------------
//  in      | to block  | i_in_valid / o_in_stall    | i_req_type, i_elapsed_ms, i_timer_id,
//          |           |                            | i_start_level, i_delay_value, i_in_seconds
//  out     | from block| o_out_valid / i_out_stall  | o_timer_out
//
// A timer request runs through accept, count store read, add/compare and write-back.
// A tick sweeps every store word, reading and rewriting each one through the store's
// single read and single write port. Out-of-range or unused requests skip the store.
// After reset a clearing pass zeroes the store before the first word.
// A request writes back while the previous result is still stalled, then holds its result in S_DONE.
`default_nettype none

module on_off_delay_timer_bank
    import odtb_pkg::*;
#(
    parameter int unsigned NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [KIND_W-1:0]  i_req_type,
    input  wire logic [MS_W-1:0]    i_elapsed_ms,
    input  wire logic [ID_W-1:0]    i_timer_id,
    input  wire logic               i_start_level,
    input  wire logic [DLY_W-1:0]   i_delay_value,
    input  wire logic               i_in_seconds,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_timer_out
);

    localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);
    localparam logic [31:0] NUM_TIMERS_U = 32'(NUM_TIMERS);

    // store word: {active mark, count}
    logic [CNT_W:0]       r_mem [NUM_TIMERS];
    logic [CNT_W:0]       r_rd_data;

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_ptr, n_ptr;
    logic                 r_out_valid, n_out_valid;
    logic                 r_timer_out, n_timer_out;
    logic                 r_res, n_res;

    logic [KIND_W-1:0]    r_kind;
    logic                 r_id_ok;
    logic [IDX_W-1:0]     r_addr;
    logic                 r_start;
    logic [SDLY_W-1:0]    r_delay;
    logic [MS_W-1:0]      r_cycle_ms;

    logic                 in_accept;
    logic                 out_free;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_wa;
    logic [CNT_W:0]       mem_wd;
    logic [IDX_W-1:0]     mem_ra;

    logic [SDLY_W-1:0]    scaled_delay;
    logic signed [CNT_W-1:0] cnt;
    logic signed [CNT_W:0]   sum;
    logic signed [CNT_W:0]   addend;
    logic [CNT_W-1:0]     ton_cnt;
    logic [CNT_W-1:0]     new_cnt;
    logic                 new_res;

    assign in_accept   = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_timer_out = r_timer_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign scaled_delay = i_in_seconds ? SDLY_W'(i_delay_value) * SDLY_W'(MS_PER_SEC)
                                       : SDLY_W'(i_delay_value);

    // item capture
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind  <= i_req_type;
            r_id_ok <= (32'(i_timer_id) < NUM_TIMERS_U);
            r_addr  <= IDX_W'(i_timer_id);
            r_start <= i_start_level;
            r_delay <= scaled_delay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_ms <= '0;
        end else if (in_accept && (i_req_type == REQ_TICK)) begin
            r_cycle_ms <= i_elapsed_ms;
        end
    end

    // count store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    // shared adder: +cycle for on-delay, -cycle for off-delay countdown
    always_comb begin
        cnt     = signed'(r_rd_data[CNT_W-1:0]);
        addend  = (r_kind == REQ_TON) ? signed'({{(CNT_W+1-MS_W){1'b0}}, r_cycle_ms})
                                      : -signed'({{(CNT_W+1-MS_W){1'b0}}, r_cycle_ms});
        sum     = signed'({cnt[CNT_W-1], cnt}) + addend;
        // positive overflow saturates
        ton_cnt = (!sum[CNT_W] && sum[CNT_W-1]) ? CNT_MAX : sum[CNT_W-1:0];
        new_cnt = r_rd_data[CNT_W-1:0];
        new_res = 1'b0;
        if (r_kind == REQ_TON) begin
            if (r_start) begin
                new_cnt = ton_cnt;
                new_res = (signed'(ton_cnt) >= signed'(CNT_W'(r_delay)));
            end else begin
                new_cnt = '0;
            end
        end else begin
            if (r_start) begin
                new_cnt = CNT_W'(r_delay);
                new_res = 1'b1;
            end else if (cnt > 0) begin
                new_cnt = sum[CNT_W-1:0];
                new_res = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_timer_out <= n_timer_out;
        r_res       <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_res       = r_res;
        n_timer_out = r_timer_out;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_wa      = r_ptr;
        mem_wd      = '0;
        mem_ra      = r_ptr;

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_ptr  = r_ptr + 1'b1;
                if (r_ptr == LAST_IDX) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_res = 1'b0;
                    priority if (i_req_type == REQ_TICK) begin
                        n_ptr   = '0;
                        n_state = S_TICK_RD;
                    end else if ((i_req_type == REQ_TON || i_req_type == REQ_TOF)
                                 && (32'(i_timer_id) < NUM_TIMERS_U)) begin
                        n_state = S_REQ_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_REQ_RD: begin
                mem_ra  = r_addr;
                n_state = S_REQ_WR;
            end
            S_REQ_WR: begin
                mem_we = 1'b1;
                mem_wa = r_addr;
                mem_wd = {1'b1, new_cnt};
                n_res  = new_res;
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_timer_out = new_res;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_TICK_RD: begin
                n_state = S_TICK_WR;
            end
            S_TICK_WR: begin
                // unmarked timers lose their count; every mark is dropped
                mem_we = 1'b1;
                mem_wd = r_rd_data[CNT_W] ? {1'b0, r_rd_data[CNT_W-1:0]} : '0;
                n_ptr  = r_ptr + 1'b1;
                n_state = S_TICK_RD;
                if (r_ptr == LAST_IDX) begin
                    n_ptr   = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_timer_out = r_res && r_id_ok;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
